[hw/rtl/refcounted_frame_allocator_unit_macros.svh]
// Assertion macros for the refcounted frame allocator.
// Used by the port checker; depends on nothing else.
`ifndef REFCOUNTED_FRAME_ALLOCATOR_UNIT_MACROS_SVH
`define REFCOUNTED_FRAME_ALLOCATOR_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RFA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RFA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/rfa_pkg.sv]
// Shared types, sizes and codes of the refcounted frame allocator.
// Used by the frame store, the range check, the top level and the checker.
`timescale 1ns / 1ps
`default_nettype none

package rfa_pkg;

  // Store geometry. COUNT_BITS must be at least IDX_W + 1 so a link fits.
  localparam int MAX_FRAMES = 1024;
  localparam int COUNT_BITS = 16;
  localparam int IDX_W      = $clog2(MAX_FRAMES);
  localparam int LINK_W     = IDX_W + 1;

  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [LINK_W-1:0]     link_t;
  typedef logic [COUNT_BITS-1:0] cnt_t;

  // One store entry: allocated flag plus a link (free) or a count (allocated).
  typedef struct packed {
    logic used;
    cnt_t val;
  } entry_t;

  // Write port of the frame store.
  typedef struct packed {
    logic   en;
    idx_t   addr;
    entry_t data;
  } mem_wr_t;

  // Result of the region check on a frame number.
  typedef struct packed {
    logic  in_range;
    idx_t  idx;
    link_t size;
  } rng_t;

  localparam link_t END_MARK  = link_t'(MAX_FRAMES);
  localparam cnt_t  COUNT_MAX = {COUNT_BITS{1'b1}};

  // Operation codes.
  localparam logic [2:0] FN_INIT  = 3'd0;
  localparam logic [2:0] FN_ALLOC = 3'd1;
  localparam logic [2:0] FN_MARK  = 3'd2;
  localparam logic [2:0] FN_INCR  = 3'd3;
  localparam logic [2:0] FN_DECR  = 3'd4;

  // Status codes.
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_RANGE   = 3'd1;
  localparam logic [2:0] ST_NONE    = 3'd2;
  localparam logic [2:0] ST_NOTALOC = 3'd3;
  localparam logic [2:0] ST_SAT     = 3'd4;

  // Configuration register indexes.
  localparam logic CFG_BASE   = 1'b0;
  localparam logic CFG_REGION = 1'b1;

endpackage

`default_nettype wire

[hw/rtl/rfa_mem.sv]
// Frame store: one entry per frame, one write and one registered read port.
// Depends on rfa_pkg for the entry and write port types.
`timescale 1ns / 1ps
`default_nettype none

module rfa_mem (
  input  wire logic            clk,
  input  wire rfa_pkg::mem_wr_t wr,
  input  wire logic            rd_en,
  input  wire rfa_pkg::idx_t   rd_addr,
  output rfa_pkg::entry_t      rd_data
);

  rfa_pkg::entry_t store [rfa_pkg::MAX_FRAMES];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      store[wr.addr] <= wr.data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= store[rd_addr];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/rfa_range.sv]
// Region check: effective region size and the store index of a frame number.
// Depends on rfa_pkg for the result struct and the store size.
`timescale 1ns / 1ps
`default_nettype none

module rfa_range (
  input  wire logic [31:0]  base_frame,
  input  wire logic [10:0]  region_frames,
  input  wire logic [31:0]  frame,
  output rfa_pkg::rng_t     rng
);

  logic [31:0] size32;
  logic [31:0] offset;

  // Clamp the region to the store capacity.
  always_comb begin
    if (32'(region_frames) > 32'(rfa_pkg::MAX_FRAMES)) begin
      size32 = 32'(rfa_pkg::MAX_FRAMES);
    end else begin
      size32 = 32'(region_frames);
    end
  end

  // Offset wraps modulo 2^32, so frames below the base fall out of range.
  assign offset       = frame - base_frame;
  assign rng.in_range = offset < size32;
  assign rng.idx      = offset[rfa_pkg::IDX_W-1:0];
  assign rng.size     = size32[rfa_pkg::LINK_W-1:0];

endmodule

`default_nettype wire

[hw/rtl/refcounted_frame_allocator_unit.sv]
// Refcounted frame allocator: sequencer around the frame store.
// Alloc, incref, decref, errors found on the first read and mark used on an allocated
// or top-of-list frame read the entry and finish in EXEC. Mark used on another frame
// walks the free list in WALK, then claims the frame in FIX when it is found. Init
// writes each entry of the region in INIT. One item at a time: a new start is taken in
// the cycle that carries done. Reset empties the free list; the store is undefined.
`timescale 1ns / 1ps
`default_nettype none

module refcounted_frame_allocator_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  func,
  input  wire logic [31:0] frame,
  output logic             done,
  output logic [31:0]      frame_out,
  output logic [15:0]      ref_count,
  output logic             is_full,
  output logic [2:0]       status,
  input  wire logic        wr_en,
  input  wire logic        wr_index,
  input  wire logic [31:0] wr_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_WALK = 3'd2;
  localparam logic [2:0] S_FIX  = 3'd3;
  localparam logic [2:0] S_INIT = 3'd4;

  logic [2:0]            state, state_next;
  logic [31:0]           base_frame;
  logic [10:0]           region_frames;
  logic [2:0]            func_q, func_q_next;
  logic                  in_q, in_q_next;
  rfa_pkg::idx_t         idx_q, idx_q_next;
  rfa_pkg::cnt_t         link_save, link_save_next;
  rfa_pkg::link_t        cur, cur_next;
  rfa_pkg::link_t        steps, steps_next;
  rfa_pkg::link_t        kk, kk_next;
  rfa_pkg::link_t        free_head, free_head_next;
  logic                  done_next;
  logic [31:0]           frame_out_next;
  logic [15:0]           ref_count_next;
  logic [2:0]            status_next;

  rfa_pkg::rng_t         rng;
  rfa_pkg::mem_wr_t      mwr;
  logic                  rd_en;
  rfa_pkg::idx_t         rd_addr;
  rfa_pkg::entry_t       ent;
  rfa_pkg::cnt_t         cnt_dec;
  rfa_pkg::link_t        step_inc;
  logic                  head_empty;

  rfa_range u_range (
    .base_frame    (base_frame),
    .region_frames (region_frames),
    .frame         (frame),
    .rng           (rng)
  );

  rfa_mem u_mem (
    .clk     (clk),
    .wr      (mwr),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (ent)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      base_frame    <= 32'd0;
      region_frames <= 11'd1024;
    end else if (wr_en) begin
      case (wr_index)
        rfa_pkg::CFG_BASE:   base_frame    <= wr_data;
        rfa_pkg::CFG_REGION: region_frames <= wr_data[10:0];
        default:             base_frame    <= base_frame;
      endcase
    end
  end

  assign busy       = (state != S_IDLE);
  assign head_empty = (free_head >= rfa_pkg::END_MARK);
  assign is_full    = head_empty;
  assign cnt_dec    = ent.val - rfa_pkg::cnt_t'(1);
  assign step_inc   = steps + rfa_pkg::link_t'(1);

  // Sequencer. Every store write and the read that follows it fall in different
  // cycles, so the read port needs no forwarding.
  always_comb begin
    state_next     = state;
    func_q_next    = func_q;
    in_q_next      = in_q;
    idx_q_next     = idx_q;
    link_save_next = link_save;
    cur_next       = cur;
    steps_next     = steps;
    kk_next        = kk;
    free_head_next = free_head;
    done_next      = 1'b0;
    frame_out_next = frame_out;
    ref_count_next = ref_count;
    status_next    = status;
    rd_en          = 1'b0;
    rd_addr        = idx_q;
    mwr.en         = 1'b0;
    mwr.addr       = idx_q;
    mwr.data.used  = 1'b1;
    mwr.data.val   = rfa_pkg::cnt_t'(1);

    case (state)
      S_IDLE: begin
        if (start) begin
          rd_en       = 1'b1;
          rd_addr     = (func == rfa_pkg::FN_ALLOC) ?
                        free_head[rfa_pkg::IDX_W-1:0] : rng.idx;
          func_q_next = func;
          in_q_next   = rng.in_range;
          idx_q_next  = rng.idx;
          state_next  = S_EXEC;
        end
      end

      S_EXEC: begin
        // The entry addressed in the accept cycle is on the read port now.
        state_next     = S_IDLE;
        done_next      = 1'b1;
        frame_out_next = 32'd0;
        ref_count_next = 16'd0;
        status_next    = rfa_pkg::ST_OK;
        case (func_q)
          rfa_pkg::FN_INIT: begin
            if (rng.size == rfa_pkg::link_t'(0)) begin
              status_next = rfa_pkg::ST_RANGE;
            end else begin
              kk_next    = rfa_pkg::link_t'(0);
              done_next  = 1'b0;
              state_next = S_INIT;
            end
          end
          rfa_pkg::FN_ALLOC: begin
            if (head_empty) begin
              status_next = rfa_pkg::ST_NONE;
            end else begin
              free_head_next = rfa_pkg::link_t'(ent.val);
              mwr.en         = 1'b1;
              mwr.addr       = free_head[rfa_pkg::IDX_W-1:0];
              frame_out_next = base_frame + 32'(free_head);
            end
          end
          rfa_pkg::FN_MARK: begin
            if (!in_q) begin
              status_next = rfa_pkg::ST_RANGE;
            end else if (ent.used) begin
              status_next = rfa_pkg::ST_OK;
            end else if (free_head == rfa_pkg::link_t'(idx_q)) begin
              free_head_next = rfa_pkg::link_t'(ent.val);
              mwr.en         = 1'b1;
            end else if (head_empty) begin
              status_next = rfa_pkg::ST_NONE;
            end else begin
              // Walk the list for the entry that links to this frame.
              link_save_next = ent.val;
              cur_next       = free_head;
              steps_next     = rfa_pkg::link_t'(0);
              rd_en          = 1'b1;
              rd_addr        = free_head[rfa_pkg::IDX_W-1:0];
              done_next      = 1'b0;
              state_next     = S_WALK;
            end
          end
          rfa_pkg::FN_INCR: begin
            if (!in_q) begin
              status_next = rfa_pkg::ST_RANGE;
            end else if (!ent.used) begin
              status_next = rfa_pkg::ST_NOTALOC;
            end else if (ent.val == rfa_pkg::COUNT_MAX) begin
              status_next    = rfa_pkg::ST_SAT;
              ref_count_next = 16'(rfa_pkg::COUNT_MAX);
            end else begin
              mwr.en         = 1'b1;
              mwr.data.val   = ent.val + rfa_pkg::cnt_t'(1);
              ref_count_next = 16'(ent.val + rfa_pkg::cnt_t'(1));
            end
          end
          rfa_pkg::FN_DECR: begin
            if (!in_q) begin
              status_next = rfa_pkg::ST_RANGE;
            end else if (!ent.used) begin
              status_next = rfa_pkg::ST_NOTALOC;
            end else begin
              mwr.en         = 1'b1;
              ref_count_next = 16'(cnt_dec);
              if (cnt_dec == rfa_pkg::cnt_t'(0)) begin
                // Last reference gone: push the frame on the free list.
                mwr.data.used  = 1'b0;
                mwr.data.val   = rfa_pkg::cnt_t'(free_head);
                free_head_next = rfa_pkg::link_t'(idx_q);
              end else begin
                mwr.data.val = cnt_dec;
              end
            end
          end
          default: begin
            status_next = rfa_pkg::ST_OK;
          end
        endcase
      end

      S_WALK: begin
        // ent is the entry at cur, a member of the free list.
        if (ent.used) begin
          done_next      = 1'b1;
          status_next    = rfa_pkg::ST_NONE;
          state_next     = S_IDLE;
        end else if (ent.val == rfa_pkg::cnt_t'(idx_q)) begin
          // Predecessor found: bypass the frame in the list.
          mwr.en        = 1'b1;
          mwr.addr      = cur[rfa_pkg::IDX_W-1:0];
          mwr.data.used = 1'b0;
          mwr.data.val  = link_save;
          state_next    = S_FIX;
        end else if (step_inc == rfa_pkg::END_MARK ||
                     32'(ent.val) >= 32'(rfa_pkg::MAX_FRAMES)) begin
          done_next   = 1'b1;
          status_next = rfa_pkg::ST_NONE;
          state_next  = S_IDLE;
        end else begin
          steps_next = step_inc;
          cur_next   = rfa_pkg::link_t'(ent.val);
          rd_en      = 1'b1;
          rd_addr    = ent.val[rfa_pkg::IDX_W-1:0];
        end
      end

      S_FIX: begin
        // Claim the unlinked frame with one reference.
        mwr.en      = 1'b1;
        done_next   = 1'b1;
        status_next = rfa_pkg::ST_OK;
        state_next  = S_IDLE;
      end

      S_INIT: begin
        // One entry per cycle: link each frame to the next, the last to the end.
        mwr.en        = 1'b1;
        mwr.addr      = kk[rfa_pkg::IDX_W-1:0];
        mwr.data.used = 1'b0;
        if (kk == rng.size - rfa_pkg::link_t'(1)) begin
          mwr.data.val   = rfa_pkg::cnt_t'(rfa_pkg::END_MARK);
          free_head_next = rfa_pkg::link_t'(0);
          done_next      = 1'b1;
          status_next    = rfa_pkg::ST_OK;
          state_next     = S_IDLE;
        end else begin
          mwr.data.val = rfa_pkg::cnt_t'(kk + rfa_pkg::link_t'(1));
          kk_next      = kk + rfa_pkg::link_t'(1);
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      free_head <= rfa_pkg::END_MARK;
      done      <= 1'b0;
    end else begin
      state     <= state_next;
      free_head <= free_head_next;
      done      <= done_next;
    end
  end

  // Operand and result registers.
  always_ff @(posedge clk) begin
    func_q    <= func_q_next;
    in_q      <= in_q_next;
    idx_q     <= idx_q_next;
    link_save <= link_save_next;
    cur       <= cur_next;
    steps     <= steps_next;
    kk        <= kk_next;
    frame_out <= frame_out_next;
    ref_count <= ref_count_next;
    status    <= status_next;
  end

endmodule

`default_nettype wire

[hw/rtl/rfa_checker.sv]
// Port checker for the refcounted frame allocator, bound to the top level.
// Depends on rfa_pkg for status codes and on the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none

`include "refcounted_frame_allocator_unit_macros.svh"

module rfa_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        done,
  input wire logic [31:0] frame_out,
  input wire logic [15:0] ref_count,
  input wire logic [2:0]  status
);

  // An accepted start always begins a busy period.
  `RFA_ASSERT_NEXT(a_start_busy, clk, rst, start && !busy, busy, "start not followed by busy")

  // A result transfer only ends a busy period.
  `RFA_ASSERT_SAME(a_done_after_busy, clk, rst, done, $past(busy), "done without work")

  // Status codes stay within the defined set.
  `RFA_ASSERT_SAME(a_status_legal, clk, rst, done, status == rfa_pkg::ST_OK || status == rfa_pkg::ST_RANGE || status == rfa_pkg::ST_NONE || status == rfa_pkg::ST_NOTALOC || status == rfa_pkg::ST_SAT, "illegal status")

  // Failed operations hand out no frame.
  `RFA_ASSERT_SAME(a_fail_no_frame, clk, rst, done && status != rfa_pkg::ST_OK, frame_out == 32'd0, "frame on failure")

  // Range, empty and free-frame failures report no count.
  `RFA_ASSERT_SAME(a_fail_no_count, clk, rst, done && (status == rfa_pkg::ST_RANGE || status == rfa_pkg::ST_NONE || status == rfa_pkg::ST_NOTALOC), ref_count == 16'd0, "count on failure")

endmodule

bind refcounted_frame_allocator_unit rfa_checker u_rfa_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .done      (done),
  .frame_out (frame_out),
  .ref_count (ref_count),
  .status    (status)
);

`default_nettype wire

[tb/sv/refcounted_frame_allocator_unit_test.sv]
// Self-checking testbench for the refcounted frame allocator unit.
// Drives directed and random operations and compares every result with a predictor.
// Depends on rfa_pkg and refcounted_frame_allocator_unit.
`timescale 1ns / 1ps

module refcounted_frame_allocator_unit_test;

  localparam int RANDOM_OPS   = 820;
  localparam int QUIET_LIMIT  = 20000;
  localparam int REPORT_LIMIT = 40;
  localparam int INCR_BURST   = 12;

  typedef struct {
    logic [2:0]  fn;
    logic [31:0] frm;
  } frame_op_t;

  typedef struct packed {
    logic [31:0] frame_out;
    logic [15:0] ref_count;
    logic        is_full;
    logic [2:0]  status;
  } alloc_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [2:0]  func = '0;
  logic [31:0] frame = '0;
  logic        wr_en = 1'b0;
  logic        wr_index = 1'b0;
  logic [31:0] wr_data = '0;
  logic        busy;
  logic        done;
  logic [31:0] frame_out;
  logic [15:0] ref_count;
  logic        is_full;
  logic [2:0]  status;

  // Operations waiting to be driven and results still owed by the block.
  frame_op_t     op_backlog[$];
  alloc_result_t owed_results[$];

  // Predictor copy of the allocator state and its configuration.
  logic                slot_used[rfa_pkg::MAX_FRAMES];
  rfa_pkg::cnt_t       slot_val[rfa_pkg::MAX_FRAMES];
  rfa_pkg::link_t      free_top;
  logic [31:0]         cfg_base;
  logic [10:0]         cfg_region;

  // Stimulus-side view of the configuration and of which entries init has written.
  logic [31:0] gen_base = '0;
  int          gen_size = rfa_pkg::MAX_FRAMES;
  int          written_hi = 0;

  bit   holding = 1'b0;
  logic op_taken = 1'b0;
  int   gap_left = 0;
  int   gap_max = 15;
  int   error_count = 0;
  int   result_count = 0;
  int   quiet_cycles = 0;

  refcounted_frame_allocator_unit dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .func      (func),
    .frame     (frame),
    .done      (done),
    .frame_out (frame_out),
    .ref_count (ref_count),
    .is_full   (is_full),
    .status    (status),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data)
  );

  always #2 clk = ~clk;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (error_count < REPORT_LIMIT) begin
      $display("[%0t] result %0d: %s got %h, want %h", $time, result_count, what, got, want);
    end
    error_count++;
  endtask

  // Applies one operation to the predictor state and returns the result it owes.
  function automatic alloc_result_t allocator_step(input logic [2:0] fn,
                                                   input logic [31:0] frm);
    alloc_result_t r;
    int            size;
    int            cur;
    int            steps;
    int            k;
    logic [31:0]   off;
    rfa_pkg::idx_t idx;
    logic          hit;
    logic          linked;
    r = '0;
    size = (int'(cfg_region) > rfa_pkg::MAX_FRAMES) ? rfa_pkg::MAX_FRAMES : int'(cfg_region);
    off = frm - cfg_base;
    hit = (off < 32'(size));
    idx = off[rfa_pkg::IDX_W-1:0];
    case (fn)
      rfa_pkg::FN_INIT: begin
        if (size == 0) begin
          r.status = rfa_pkg::ST_RANGE;
        end else begin
          for (k = 0; k < size; k++) begin
            slot_used[k] = 1'b0;
            slot_val[k] = rfa_pkg::cnt_t'(k + 1);
          end
          slot_val[size-1] = rfa_pkg::cnt_t'(rfa_pkg::END_MARK);
          free_top = '0;
        end
      end
      rfa_pkg::FN_ALLOC: begin
        if (free_top >= rfa_pkg::END_MARK) begin
          r.status = rfa_pkg::ST_NONE;
        end else begin
          idx = free_top[rfa_pkg::IDX_W-1:0];
          free_top = rfa_pkg::link_t'(slot_val[idx]);
          slot_used[idx] = 1'b1;
          slot_val[idx] = rfa_pkg::cnt_t'(1);
          r.frame_out = cfg_base + 32'(idx);
        end
      end
      rfa_pkg::FN_MARK: begin
        if (!hit) begin
          r.status = rfa_pkg::ST_RANGE;
        end else if (!slot_used[idx]) begin
          // Unlink the frame: directly from the top, else by walking to its predecessor.
          linked = 1'b0;
          if (free_top == rfa_pkg::link_t'(idx)) begin
            free_top = rfa_pkg::link_t'(slot_val[idx]);
            linked = 1'b1;
          end else begin
            cur = int'(free_top);
            for (steps = 0; steps < rfa_pkg::MAX_FRAMES; steps++) begin
              if (cur >= rfa_pkg::MAX_FRAMES || slot_used[cur]) break;
              if (slot_val[cur] == rfa_pkg::cnt_t'(idx)) begin
                slot_val[cur] = slot_val[idx];
                linked = 1'b1;
                break;
              end
              cur = int'(slot_val[cur]);
            end
          end
          if (linked) begin
            slot_used[idx] = 1'b1;
            slot_val[idx] = rfa_pkg::cnt_t'(1);
          end else begin
            r.status = rfa_pkg::ST_NONE;
          end
        end
      end
      rfa_pkg::FN_INCR: begin
        if (!hit) begin
          r.status = rfa_pkg::ST_RANGE;
        end else if (!slot_used[idx]) begin
          r.status = rfa_pkg::ST_NOTALOC;
        end else begin
          if (slot_val[idx] == rfa_pkg::COUNT_MAX) r.status = rfa_pkg::ST_SAT;
          else slot_val[idx] = slot_val[idx] + 1'b1;
          r.ref_count = slot_val[idx];
        end
      end
      rfa_pkg::FN_DECR: begin
        if (!hit) begin
          r.status = rfa_pkg::ST_RANGE;
        end else if (!slot_used[idx]) begin
          r.status = rfa_pkg::ST_NOTALOC;
        end else begin
          r.ref_count = slot_val[idx] - 1'b1;
          // A count that reaches zero returns the frame to the top of the free list.
          if (r.ref_count == '0) begin
            slot_used[idx] = 1'b0;
            slot_val[idx] = rfa_pkg::cnt_t'(free_top);
            free_top = rfa_pkg::link_t'(idx);
          end else begin
            slot_val[idx] = r.ref_count;
          end
        end
      end
      default: begin
      end
    endcase
    r.is_full = (free_top >= rfa_pkg::END_MARK);
    return r;
  endfunction

  // Driver: presents queued operations, holding each until its transfer.
  always @(negedge clk) begin
    frame_op_t op;
    if (!rst) begin
      if (holding && op_taken) holding = 1'b0;
      if (!holding && op_backlog.size() > 0) begin
        if (gap_left > 0) begin
          gap_left--;
        end else begin
          op = op_backlog.pop_front();
          func <= op.fn;
          frame <= op.frm;
          holding = 1'b1;
          gap_left = $urandom_range(0, gap_max);
        end
      end
      start <= holding;
    end
  end

  // Monitor: checks results, tracks register writes and predicts each accepted operation.
  always @(posedge clk) begin
    alloc_result_t seen;
    alloc_result_t want;
    if (rst) begin
      free_top = rfa_pkg::END_MARK;
      cfg_base = '0;
      cfg_region = 11'(rfa_pkg::MAX_FRAMES);
      op_taken <= 1'b0;
      quiet_cycles = 0;
    end else begin
      if (done) begin
        seen.frame_out = frame_out;
        seen.ref_count = ref_count;
        seen.is_full = is_full;
        seen.status = status;
        result_count++;
        if (owed_results.size() == 0) begin
          report_mismatch("result with nothing owed", '0, '0);
        end else begin
          want = owed_results.pop_front();
          if (seen.frame_out !== want.frame_out)
            report_mismatch("frame_out", seen.frame_out, want.frame_out);
          if (seen.ref_count !== want.ref_count)
            report_mismatch("ref_count", 32'(seen.ref_count), 32'(want.ref_count));
          if (seen.is_full !== want.is_full)
            report_mismatch("is_full", 32'(seen.is_full), 32'(want.is_full));
          if (seen.status !== want.status)
            report_mismatch("status", 32'(seen.status), 32'(want.status));
        end
      end
      if (wr_en) begin
        if (wr_index == rfa_pkg::CFG_BASE) cfg_base = wr_data;
        else cfg_region = wr_data[10:0];
      end
      op_taken <= start && !busy;
      if (start && !busy) owed_results.push_back(allocator_step(func, frame));
      // Watchdog on cycles without any transfer.
      if (done || (start && !busy)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic queue_op(input logic [2:0] fn, input logic [31:0] frm);
    frame_op_t op;
    op.fn = fn;
    op.frm = frm;
    op_backlog.push_back(op);
    if (fn == rfa_pkg::FN_INIT && gen_size > written_hi) written_hi = gen_size;
  endtask

  task automatic wait_idle();
    while (op_backlog.size() != 0 || holding || owed_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] data);
    @(negedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= data;
    @(negedge clk);
    wr_en <= 1'b0;
  endtask

  // Register writes only happen once the block has returned every result.
  task automatic configure(input logic [31:0] base, input logic [10:0] region);
    wait_idle();
    write_reg(rfa_pkg::CFG_BASE, base);
    write_reg(rfa_pkg::CFG_REGION, 32'(region));
    gen_base = base;
    gen_size = (int'(region) > rfa_pkg::MAX_FRAMES) ? rfa_pkg::MAX_FRAMES : int'(region);
  endtask

  // Often low frames of the region, where allocations land first after init.
  function automatic logic [31:0] pick_frame();
    int hot;
    hot = (gen_size < 6) ? gen_size : 6;
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return gen_base + 32'(gen_size) + $urandom_range(0, 3);
      2: return gen_base - 32'($urandom_range(1, 2));
      3, 4, 5: if (gen_size > 0) return gen_base + $urandom_range(0, gen_size - 1);
      default: if (hot > 0) return gen_base + $urandom_range(0, hot - 1);
    endcase
    return $urandom();
  endfunction

  function automatic logic [2:0] pick_func();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 3) return rfa_pkg::FN_INIT;
    if (roll < 33) return rfa_pkg::FN_ALLOC;
    if (roll < 58) return rfa_pkg::FN_INCR;
    if (roll < 83) return rfa_pkg::FN_DECR;
    if (roll < 96) return rfa_pkg::FN_MARK;
    return rfa_pkg::FN_DECR + 3'($urandom_range(1, 3));
  endfunction

  initial begin
    logic [31:0] base;
    logic [10:0] region;
    int          random_ops;
    int          n;
    random_ops = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Before any init: empty list, unknown operation, frames outside the region.
    queue_op(rfa_pkg::FN_ALLOC, '0);
    queue_op(rfa_pkg::FN_DECR + 3'd3, 32'hFFFF_FFFF);
    queue_op(rfa_pkg::FN_INCR, 32'd1024);
    queue_op(rfa_pkg::FN_MARK, 32'hFFFF_FFFF);

    // A region that wraps past the top of the frame number space.
    configure(32'hFFFF_FFFC, 11'd8);
    queue_op(rfa_pkg::FN_INIT, '0);
    queue_op(rfa_pkg::FN_ALLOC, '0);
    queue_op(rfa_pkg::FN_ALLOC, '0);
    queue_op(rfa_pkg::FN_INCR, gen_base);
    queue_op(rfa_pkg::FN_DECR, gen_base);
    queue_op(rfa_pkg::FN_DECR, gen_base + 1);
    queue_op(rfa_pkg::FN_INCR, gen_base + 1);
    queue_op(rfa_pkg::FN_DECR, gen_base + 1);
    queue_op(rfa_pkg::FN_MARK, gen_base + 1);
    queue_op(rfa_pkg::FN_MARK, gen_base + 7);
    queue_op(rfa_pkg::FN_MARK, gen_base);
    queue_op(rfa_pkg::FN_MARK, gen_base + 3);
    queue_op(rfa_pkg::FN_DECR, gen_base + 8);
    queue_op(rfa_pkg::FN_DECR + 3'd1, $urandom());
    queue_op(rfa_pkg::FN_DECR + 3'd2, $urandom());
    repeat (5) queue_op(rfa_pkg::FN_ALLOC, '0);
    queue_op(rfa_pkg::FN_DECR, gen_base + 5);

    // Shrink and re-init, then widen again: frame 5 is free but off the list.
    configure(32'hFFFF_FFFC, 11'd4);
    queue_op(rfa_pkg::FN_INIT, '0);
    configure(32'hFFFF_FFFC, 11'd8);
    queue_op(rfa_pkg::FN_MARK, gen_base + 5);
    queue_op(rfa_pkg::FN_MARK, gen_base + 4);
    queue_op(rfa_pkg::FN_DECR, gen_base + 6);
    queue_op(rfa_pkg::FN_ALLOC, '0);

    // Empty region: init is refused, alloc still pops the old list.
    configure('0, 11'd0);
    queue_op(rfa_pkg::FN_INIT, '0);
    queue_op(rfa_pkg::FN_ALLOC, '0);
    queue_op(rfa_pkg::FN_INCR, '0);

    // Single-frame region.
    configure(32'h8000_0000, 11'd1);
    queue_op(rfa_pkg::FN_INIT, '0);
    queue_op(rfa_pkg::FN_ALLOC, '0);
    queue_op(rfa_pkg::FN_ALLOC, '0);
    queue_op(rfa_pkg::FN_DECR, gen_base);
    queue_op(rfa_pkg::FN_MARK, gen_base);
    queue_op(rfa_pkg::FN_INCR, gen_base);

    // Region above capacity is clamped; mark the last free frame after a full walk.
    configure('0, 11'd2047);
    queue_op(rfa_pkg::FN_INIT, '0);
    queue_op(rfa_pkg::FN_ALLOC, '0);
    queue_op(rfa_pkg::FN_MARK, 32'd1023);
    queue_op(rfa_pkg::FN_MARK, 32'd1024);
    queue_op(rfa_pkg::FN_INCR, '0);
    queue_op(rfa_pkg::FN_DECR, '0);

    // Raise and lower one count with back-to-back transfers.
    configure(32'h0001_0000, 11'd2);
    gap_max = 0;
    queue_op(rfa_pkg::FN_INIT, '0);
    queue_op(rfa_pkg::FN_ALLOC, '0);
    repeat (INCR_BURST) queue_op(rfa_pkg::FN_INCR, gen_base);
    repeat (INCR_BURST) queue_op(rfa_pkg::FN_DECR, gen_base);
    queue_op(rfa_pkg::FN_DECR, gen_base);

    // Random phases, mostly with small regions.
    while (random_ops < RANDOM_OPS) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: region = 11'($urandom_range(1, 16));
        12, 13: region = 11'($urandom_range(17, 64));
        14: region = 11'd0;
        15: region = 11'd1;
        16: region = 11'(rfa_pkg::MAX_FRAMES);
        17: region = 11'($urandom_range(rfa_pkg::MAX_FRAMES + 1, 2047));
        default: region = 11'($urandom_range(65, rfa_pkg::MAX_FRAMES - 1));
      endcase
      case ($urandom_range(0, 3))
        0: base = '0;
        1: base = '1;
        2: base = 32'hFFFF_FFFF - $urandom_range(0, 20);
        default: base = $urandom();
      endcase
      configure(base, region);
      gap_max = ($urandom_range(0, 3) == 0) ? 0 : 15;
      if (gen_size > written_hi || $urandom_range(0, 1) == 1) begin
        queue_op(rfa_pkg::FN_INIT, $urandom());
      end
      n = $urandom_range(20, 60);
      repeat (n) queue_op(pick_func(), pick_frame());
      random_ops += n;
    end

    wait_idle();
    repeat (8) @(negedge clk);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
